FILE: rtl/ocl_pkg.sv
package ocl_pkg;

  // List geometry.
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int VAL_W    = 32;

  // Operation codes.
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_PREPEND = 2'd1;
  localparam logic [1:0] OP_REMOVE  = 2'd2;
  localparam logic [1:0] OP_DISPLAY = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last_of_run;
  } out_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic shr;       // take the left neighbor's value (prepend)
    logic rot;       // take the right neighbor's value (ring rotation)
    logic collapse;  // cells at or past the scan token take the right value
    logic step;      // advance the scan token by one cell
    logic clear;     // drop the scan token and the passed marks
  } cell_cmd_t;

endpackage

FILE: rtl/ocl_cell.sv
module ocl_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ocl_pkg::cell_cmd_t        cmd,
  input  logic                      load_en,
  input  logic [ocl_pkg::VAL_W-1:0] load_val,
  input  logic [ocl_pkg::VAL_W-1:0] left_val,
  input  logic [ocl_pkg::VAL_W-1:0] right_val,
  input  logic [ocl_pkg::VAL_W-1:0] key,
  input  logic                      tok_in,
  output logic [ocl_pkg::VAL_W-1:0] val,
  output logic                      tok,
  output logic                      match
);
  import ocl_pkg::*;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             tok_r, tok_nxt;
  logic             passed_r, passed_nxt;

  // Value held by this cell and handed to its neighbors.
  always_comb begin
    val_nxt = val_r;
    if (load_en) begin
      val_nxt = load_val;
    end else if (cmd.shr) begin
      val_nxt = left_val;
    end else if (cmd.rot) begin
      val_nxt = right_val;
    end else if (cmd.collapse && !passed_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // Scan token moves one cell per step; passed marks the cells behind it.
  always_comb begin
    tok_nxt    = tok_r;
    passed_nxt = passed_r;
    if (cmd.clear) begin
      tok_nxt    = 1'b0;
      passed_nxt = 1'b0;
    end else if (cmd.step) begin
      tok_nxt    = tok_in;
      passed_nxt = passed_r | tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= 1'b0;
      passed_r <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      passed_r <= passed_nxt;
    end
  end

  assign val   = val_r;
  assign tok   = tok_r;
  assign match = tok_r && (val_r == key);

endmodule

FILE: rtl/ordered_list_with_key_delete.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a chain of
// cells, one value per cell, cell 0 being the head. A request is taken when
// start is high and busy is low, and each result appears on out_item for
// exactly one cycle with out_strobe high; the receiver cannot stall, so it
// must take every strobed result. Append loads one cell and prepend shifts
// the chain. Remove walks a token through the chain, one cell per cycle; the
// gap closes in the cycle the match is found. Display rotates the whole ring
// once through cell 0, giving one result per cycle for entry_count of them.
// Every result is registered and appears in the cycle after the one that
// produces it. An empty remove or display answers with ST_EMPTY without a
// scan or rotation.
module ordered_list_with_key_delete (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ocl_pkg::in_t   in_item,
  output logic           out_strobe,
  output ocl_pkg::out_t  out_item
);
  import ocl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] rot_r, rot_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_item_r, out_item_nxt;

  cell_cmd_t        cmd;
  logic             tok_start;
  logic             do_append;
  logic             accept;
  logic             full;
  logic             found;

  logic [CAPACITY-1:0][VAL_W-1:0] vals;
  logic [CAPACITY-1:0]            toks;
  logic [CAPACITY-1:0]            hits;
  logic [CAPACITY-1:0]            loads;

  assign accept = start && (state_r == S_IDLE);
  assign full   = (cnt_r == CNT_W'(CAPACITY));
  assign found  = |hits;

  // Sequencer for the list operations.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    rot_nxt       = rot_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '{status: ST_OK, entry_value: '0, last_of_run: 1'b1};
    cmd           = '0;
    tok_start     = 1'b0;
    do_append     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          unique case (in_item.func)
            OP_APPEND: begin
              if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                do_append = 1'b1;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_PREPEND: begin
              if (full) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                cmd.shr = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_REMOVE: begin
              if (cnt_r == '0) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                key_nxt       = in_item.item_value;
                pos_nxt       = '0;
                cmd.step      = 1'b1;
                tok_start     = 1'b1;
                state_nxt     = S_SCAN;
              end
            end
            OP_DISPLAY: begin
              if (cnt_r == '0) begin
                out_item_nxt.status = ST_EMPTY;
              end else begin
                out_valid_nxt = 1'b0;
                rot_nxt       = '0;
                state_nxt     = S_SHOW;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // The token sits on cell pos_r; test it and move on or finish.
        if (found) begin
          cmd.collapse  = 1'b1;
          cmd.clear     = 1'b1;
          cnt_nxt       = cnt_r - 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if ({1'b0, pos_r} == CNT_W'(cnt_r - 1'b1)) begin
          cmd.clear           = 1'b1;
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_NOT_FOUND;
          state_nxt           = S_IDLE;
        end else begin
          cmd.step = 1'b1;
          pos_nxt  = pos_r + 1'b1;
        end
      end
      S_SHOW: begin
        // Cell 0 holds entry rot_r of the list while the ring turns.
        cmd.rot = 1'b1;
        rot_nxt = rot_r + 1'b1;
        if ({1'b0, rot_r} < cnt_r) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.entry_value = vals[0];
          out_item_nxt.last_of_run = ({1'b0, rot_r} == CNT_W'(cnt_r - 1'b1));
        end
        if (rot_r == IDX_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    rot_r      <= rot_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  // The chain of cells; the ends wrap for rotation and take the new head.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    logic             tin;

    assign loads[i] = do_append && (cnt_r == CNT_W'(i));
    if (i == 0) begin : g_head
      assign left_v = in_item.item_value;
      assign tin    = tok_start;
    end else begin : g_body
      assign left_v = vals[i-1];
      assign tin    = toks[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = vals[0];
    end else begin : g_next
      assign right_v = vals[i+1];
    end

    ocl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .load_en   (loads[i]),
      .load_val  (in_item.item_value),
      .left_val  (left_v),
      .right_val (right_v),
      .key       (key_r),
      .tok_in    (tin),
      .val       (vals[i]),
      .tok       (toks[i]),
      .match     (hits[i])
    );
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_item   = out_item_r;

  // At most one cell carries the scan token.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(toks))
    else $error("more than one scan token in the chain");

  // No token is left behind once the block is idle.
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (toks == '0))
    else $error("scan token present while idle");

  // A successful append grows the list by one.
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.func == OP_APPEND && !full) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("append did not grow the entry count");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

  // Any result with a status other than ST_OK ends its request.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_OK) |-> out_item.last_of_run)
    else $error("status result not marked last");

endmodule
